// ===== rtl/pm0_pkg.sv =====
// Shared constants for the PM/0 register-stack machine step block.
package pm0_pkg;
    localparam int STACK_DEPTH_DEF = 2048;
    localparam int NUM_REGS_DEF    = 8;
    localparam int MAX_LEVELS_DEF  = 15;
    localparam int PTR_W           = 12;
    localparam int WORD_W          = 32;

    localparam logic [4:0] OP_LIT = 5'd1;
    localparam logic [4:0] OP_RTN = 5'd2;
    localparam logic [4:0] OP_LOD = 5'd3;
    localparam logic [4:0] OP_STO = 5'd4;
    localparam logic [4:0] OP_CAL = 5'd5;
    localparam logic [4:0] OP_INC = 5'd6;
    localparam logic [4:0] OP_JMP = 5'd7;
    localparam logic [4:0] OP_JPC = 5'd8;
    localparam logic [4:0] OP_SIO = 5'd9;
    localparam logic [4:0] OP_NEG = 5'd10;
    localparam logic [4:0] OP_ADD = 5'd11;
    localparam logic [4:0] OP_SUB = 5'd12;
    localparam logic [4:0] OP_MUL = 5'd13;
    localparam logic [4:0] OP_DIV = 5'd14;
    localparam logic [4:0] OP_ODD = 5'd15;
    localparam logic [4:0] OP_MOD = 5'd16;
    localparam logic [4:0] OP_EQL = 5'd17;
    localparam logic [4:0] OP_NEQ = 5'd18;
    localparam logic [4:0] OP_LSS = 5'd19;
    localparam logic [4:0] OP_LEQ = 5'd20;
    localparam logic [4:0] OP_GTR = 5'd21;
    localparam logic [4:0] OP_GEQ = 5'd22;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_DIV0 = 2'd1;
    localparam logic [1:0] FAULT_ADDR = 2'd2;

    localparam logic [31:0] SIO_OUT  = 32'sd1;
    localparam logic [31:0] SIO_IN   = 32'sd2;
    localparam logic [31:0] SIO_HALT = 32'sd3;
endpackage

// ===== rtl/pm0_register_stack_machine_step.sv =====
// PM/0 register-stack machine executing one instruction per transaction.
//
// Input channel: i_valid / o_stall carry one fetched instruction (opcode, R,
// L, M) and the value for the input instruction. Output channel: o_valid /
// i_stall carry the PC, BP and SP afterwards, the output value, the halt flag
// and a fault code. One instruction is in flight at a time.
// After reset the block first clears the whole stack memory, one word a cycle,
// during which o_stall is high.
// Each instruction passes through its states in turn: a static-link walk
// reads one word per level; LOD reads its word after any walk; CAL writes
// four words; RTN reads two words; DIV and MOD run a radix-2 divider of 32
// iterations. The stack memory is single-ported, so these reads and writes
// take place one at a time.
// The result sits in an output register; while i_stall holds it there the
// block accepts no new instruction until the result has been taken.
module pm0_register_stack_machine_step
    import pm0_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [4:0]          i_opcode,
    input  logic [2:0]          i_reg_sel,
    input  logic [3:0]          i_level_sel,
    input  logic signed [31:0]  i_operand_m,
    input  logic signed [31:0]  i_read_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [PTR_W-1:0]    o_next_pc,
    output logic [PTR_W-1:0]    o_base_ptr_out,
    output logic [PTR_W-1:0]    o_stack_ptr_out,
    output logic                o_out_valid,
    output logic signed [31:0]  o_out_value,
    output logic                o_halted,
    output logic [1:0]          o_fault
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int RW = $clog2(NUM_REGS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WALK  = 4'd2;
    localparam logic [3:0] S_WALKW = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_LODW  = 4'd5;
    localparam logic [3:0] S_CALW  = 4'd6;
    localparam logic [3:0] S_RTN1  = 4'd7;
    localparam logic [3:0] S_RTN2  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [WORD_W-1:0] r_mem [STACK_DEPTH];
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_regs [NUM_REGS];

    logic [3:0]        r_state;
    logic [AW:0]       r_clr;
    logic [PTR_W-1:0]  r_pc, r_bp, r_sp;
    logic              r_halt;
    logic [4:0]        r_op;
    logic [2:0]        r_r;
    logic [31:0]       r_m, r_rd;
    logic [3:0]        r_lv;
    logic signed [32:0] r_base;
    logic [1:0]        r_ccnt;
    logic              r_ovalid;
    logic [31:0]       r_ov;
    logic [1:0]        r_fault;
    logic [31:0]       r_a, r_b;
    // divider
    logic [31:0]       r_quo, r_rem, r_dvs;
    logic [5:0]        r_dcnt;
    logic              r_negq, r_negr;
    logic              r_ovld;

    // memory port
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    function automatic logic in_range(input logic signed [33:0] a);
        return (a >= 34'sd0) && (a < 34'(STACK_DEPTH));
    endfunction

    logic signed [33:0] walk_addr, lod_addr, sp_ext, bp_ext;
    assign walk_addr = 34'(r_base) + 34'sd1;
    assign lod_addr  = 34'(r_base) + 34'(signed'(r_m)) - 34'sd1;
    assign sp_ext    = 34'($unsigned(r_sp));
    assign bp_ext    = 34'($unsigned(r_bp));

    logic [31:0] r_reg_r;
    assign r_reg_r = r_regs[r_r];

    logic [PTR_W-1:0] cal_ptr;
    assign cal_ptr = r_sp + PTR_W'(r_ccnt) + PTR_W'(1);

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_clr[AW-1:0];
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_WALK: mem_addr = walk_addr[AW-1:0];
            S_EXEC: begin
                if (r_op == OP_LOD || r_op == OP_STO) begin
                    mem_addr  = lod_addr[AW-1:0];
                    mem_we    = (r_op == OP_STO) && in_range(lod_addr);
                    mem_wdata = r_reg_r;
                end else if (r_op == OP_RTN) begin
                    mem_addr = AW'(bp_ext + 34'sd2);
                end
            end
            S_RTN1: mem_addr = AW'(bp_ext + 34'sd3);
            S_CALW: begin
                mem_we   = 1'b1;
                mem_addr = AW'(cal_ptr);
                case (r_ccnt)
                    2'd0: mem_wdata = '0;
                    2'd1: mem_wdata = r_base[31:0];
                    2'd2: mem_wdata = 32'(r_bp);
                    default: mem_wdata = 32'(r_pc);
                endcase
            end
            default: ;
        endcase
    end

    // register-file ops
    logic signed [31:0] sa, sb;
    assign sa = r_a;
    assign sb = r_b;

    logic [31:0] alu;
    always_comb begin
        case (r_op)
            OP_NEG:  alu = 32'd0 - r_a;
            OP_ADD:  alu = r_a + r_b;
            OP_SUB:  alu = r_a - r_b;
            OP_ODD:  alu = {31'd0, r_reg_r[0]};
            OP_EQL:  alu = {31'd0, sa == sb};
            OP_NEQ:  alu = {31'd0, sa != sb};
            OP_LSS:  alu = {31'd0, sa < sb};
            OP_LEQ:  alu = {31'd0, sa <= sb};
            OP_GTR:  alu = {31'd0, sa > sb};
            OP_GEQ:  alu = {31'd0, sa >= sb};
            default: alu = r_a[15:0] * r_b[15:0] + ((r_a[31:16] * r_b[15:0]
                           + r_a[15:0] * r_b[31:16]) << 16);
        endcase
    end

    logic [32:0] dsub;
    assign dsub = {r_rem, r_quo[31]} - {1'b0, r_dvs};

    logic [31:0] absa, absb;
    assign absa = r_a[31] ? 32'd0 - r_a : r_a;
    assign absb = r_b[31] ? 32'd0 - r_b : r_b;

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pc    <= '0;
            r_bp    <= PTR_W'(1);
            r_sp    <= '0;
            r_halt  <= 1'b0;
            o_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) r_regs[i] <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(STACK_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op     <= i_opcode;
                        r_r      <= i_reg_sel;
                        r_lv     <= (i_level_sel > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS)
                                                                   : i_level_sel;
                        r_m      <= i_operand_m;
                        r_rd     <= i_read_value;
                        r_a      <= r_regs[i_level_sel[RW-1:0]];
                        r_b      <= r_regs[i_operand_m[RW-1:0]];
                        r_base   <= 33'($unsigned(r_bp));
                        r_ovalid <= 1'b0;
                        r_ov     <= '0;
                        r_fault  <= FAULT_NONE;
                        r_ccnt   <= '0;
                        if (r_halt) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pc <= r_pc + 1'b1;
                            r_state <= ((i_opcode == OP_LOD || i_opcode == OP_STO ||
                                         i_opcode == OP_CAL) && i_level_sel != 4'd0)
                                       ? S_WALK : S_EXEC;
                        end
                    end
                end
                S_WALK: begin
                    if (!in_range(walk_addr)) begin
                        r_fault <= FAULT_ADDR;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WALKW;
                    end
                end
                S_WALKW: begin
                    r_base <= 33'(signed'(r_rdata));
                    r_lv   <= r_lv - 1'b1;
                    r_state <= (r_lv == 4'd1) ? S_EXEC : S_WALK;
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    case (r_op)
                        OP_LIT: r_regs[r_r] <= r_m;
                        OP_RTN: begin
                            if (!in_range(bp_ext + 34'sd2) || !in_range(bp_ext + 34'sd3))
                                r_fault <= FAULT_ADDR;
                            else
                                r_state <= S_RTN1;
                        end
                        OP_LOD, OP_STO: begin
                            if (!in_range(lod_addr)) r_fault <= FAULT_ADDR;
                            else if (r_op == OP_LOD) r_state <= S_LODW;
                        end
                        OP_CAL: begin
                            if (!in_range(sp_ext + 34'sd1) || !in_range(sp_ext + 34'sd4))
                                r_fault <= FAULT_ADDR;
                            else
                                r_state <= S_CALW;
                        end
                        OP_INC: r_sp <= r_sp + r_m[PTR_W-1:0];
                        OP_JMP: r_pc <= r_m[PTR_W-1:0];
                        OP_JPC: if (r_reg_r == '0) r_pc <= r_m[PTR_W-1:0];
                        OP_SIO: begin
                            if (r_m == SIO_OUT) begin
                                r_ovalid <= 1'b1;
                                r_ov     <= r_reg_r;
                            end else if (r_m == SIO_IN) begin
                                r_regs[r_r] <= r_rd;
                            end else if (r_m == SIO_HALT) begin
                                r_halt <= 1'b1;
                            end
                        end
                        OP_DIV, OP_MOD: begin
                            if (r_b == '0) begin
                                r_regs[r_r] <= '0;
                                r_fault <= FAULT_DIV0;
                            end else begin
                                r_quo   <= absa;
                                r_rem   <= '0;
                                r_dvs   <= absb;
                                r_dcnt  <= '0;
                                r_negq  <= r_a[31] ^ r_b[31];
                                r_negr  <= r_a[31];
                                r_state <= S_DIV;
                            end
                        end
                        OP_NEG, OP_ADD, OP_SUB, OP_MUL, OP_ODD, OP_EQL, OP_NEQ,
                        OP_LSS, OP_LEQ, OP_GTR, OP_GEQ: r_regs[r_r] <= alu;
                        default: ;
                    endcase
                end
                S_LODW: begin
                    r_regs[r_r] <= r_rdata;
                    r_state <= S_DONE;
                end
                S_CALW: begin
                    r_ccnt <= r_ccnt + 1'b1;
                    if (r_ccnt == 2'd3) begin
                        r_bp <= r_sp + PTR_W'(1);
                        r_sp <= r_sp + PTR_W'(4);
                        r_pc <= r_m[PTR_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_RTN1: begin
                    r_base  <= 33'(r_rdata[PTR_W-1:0]);
                    r_state <= S_RTN2;
                end
                S_RTN2: begin
                    r_sp <= r_bp - 1'b1;
                    r_bp <= r_base[PTR_W-1:0];
                    r_pc <= r_rdata[PTR_W-1:0];
                    r_state <= S_DONE;
                end
                S_DIV: begin
                    if (dsub[32]) begin
                        r_rem <= {r_rem[30:0], r_quo[31]};
                        r_quo <= {r_quo[30:0], 1'b0};
                    end else begin
                        r_rem <= dsub[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 6'd31) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_op == OP_DIV && r_ovld)
                        r_regs[r_r] <= r_negq ? 32'd0 - r_quo : r_quo;
                    else if (r_op == OP_MOD && r_ovld)
                        r_regs[r_r] <= r_negr ? 32'd0 - r_rem : r_rem;
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // DIV/MOD write back only when the divider actually ran this transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (r_state == S_DIV) r_ovld <= 1'b1;
        else if (r_state == S_OUT) r_ovld <= 1'b0;
    end

    assign o_next_pc       = r_pc;
    assign o_base_ptr_out  = r_bp;
    assign o_stack_ptr_out = r_sp;
    assign o_out_valid     = r_ovalid;
    assign o_out_value     = r_ov;
    assign o_halted        = r_halt;
    assign o_fault         = r_fault;
endmodule

// ===== rtl/pm0_checker.sv =====
// Port-level checker for the PM/0 machine step block, bound to the step block module.
module pm0_checker
    import pm0_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_out_valid,
    input logic [31:0] o_out_value,
    input logic        o_halted,
    input logic [1:0]  o_fault
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_value))
        else $error("stalled result changed");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_halted |=> o_halted)
        else $error("halt flag dropped");
    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fault != 2'd3)
        else $error("illegal fault code");
    a_out_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> o_fault == FAULT_NONE)
        else $error("output with fault");
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted while result pending");
endmodule

bind pm0_register_stack_machine_step pm0_checker u_pm0_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the PM/0 register-stack machine step block.
module testbench
    import pm0_pkg::*;
();

    localparam int DEPTH    = 2048;
    localparam int LEVELS   = 15;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [11:0] pc;
        logic [11:0] bp;
        logic [11:0] sp;
        logic        ov;
        logic [31:0] oval;
        logic        halt;
        logic [1:0]  flt;
    } t_step_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [4:0]  i_opcode;
    logic [2:0]  i_reg_sel;
    logic [3:0]  i_level_sel;
    logic signed [31:0] i_operand_m;
    logic signed [31:0] i_read_value;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_next_pc;
    logic [11:0] o_base_ptr_out;
    logic [11:0] o_stack_ptr_out;
    logic        o_out_valid;
    logic signed [31:0] o_out_value;
    logic        o_halted;
    logic [1:0]  o_fault;

    pm0_register_stack_machine_step uut (.*);

    // Shadow machine state.
    logic [31:0] mdl_stack [DEPTH];
    logic [31:0] mdl_regs [8];
    logic [11:0] mdl_pc, mdl_bp, mdl_sp;
    logic        mdl_halt;

    t_step_out pending_steps[$];
    int mismatches;
    int checked;
    int sent;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit in_stack(longint a);
        return a >= 0 && a < DEPTH;
    endfunction

    function automatic bit walk_links(logic [3:0] lv, output longint base);
        longint b;
        int n;
        b = mdl_bp;
        n = (lv > LEVELS) ? LEVELS : lv;
        for (int i = 0; i < n; i++) begin
            if (!in_stack(b + 1)) return 0;
            b = longint'($signed(mdl_stack[b + 1]));
        end
        base = b;
        return 1;
    endfunction

    function automatic t_step_out execute_instr(logic [4:0] op, logic [2:0] r,
                                                logic [3:0] lv, logic [31:0] m,
                                                logic [31:0] rd);
        t_step_out res;
        logic [31:0] a, b;
        longint sa, sb, base, addr, s, mm;
        res = '0;
        if (!mdl_halt) begin
            a  = mdl_regs[lv[2:0]];
            b  = mdl_regs[m[2:0]];
            sa = longint'($signed(a));
            sb = longint'($signed(b));
            mm = longint'($signed(m));
            mdl_pc = mdl_pc + 12'd1;
            case (op)
                OP_LIT: mdl_regs[r] = m;
                OP_RTN: begin
                    s = longint'(mdl_bp) - 1;
                    if (!in_stack(s + 3) || !in_stack(s + 4)) begin
                        res.flt = FAULT_ADDR;
                    end else begin
                        mdl_sp = s[11:0];
                        mdl_bp = mdl_stack[s + 3][11:0];
                        mdl_pc = mdl_stack[s + 4][11:0];
                    end
                end
                OP_LOD, OP_STO: begin
                    if (!walk_links(lv, base)) begin
                        res.flt = FAULT_ADDR;
                    end else begin
                        addr = base + mm - 1;
                        if (!in_stack(addr)) res.flt = FAULT_ADDR;
                        else if (op == OP_LOD) mdl_regs[r] = mdl_stack[addr];
                        else mdl_stack[addr] = mdl_regs[r];
                    end
                end
                OP_CAL: begin
                    s = mdl_sp;
                    if (!walk_links(lv, base) || !in_stack(s + 1) || !in_stack(s + 4)) begin
                        res.flt = FAULT_ADDR;
                    end else begin
                        mdl_stack[s + 1] = '0;
                        mdl_stack[s + 2] = base[31:0];
                        mdl_stack[s + 3] = 32'(mdl_bp);
                        mdl_stack[s + 4] = 32'(mdl_pc);
                        mdl_bp = 12'(s + 1);
                        mdl_sp = 12'(s + 4);
                        mdl_pc = m[11:0];
                    end
                end
                OP_INC: mdl_sp = mdl_sp + m[11:0];
                OP_JMP: mdl_pc = m[11:0];
                OP_JPC: if (mdl_regs[r] == 0) mdl_pc = m[11:0];
                OP_SIO: begin
                    if (m == SIO_OUT) begin
                        res.ov   = 1'b1;
                        res.oval = mdl_regs[r];
                    end else if (m == SIO_IN) begin
                        mdl_regs[r] = rd;
                    end else if (m == SIO_HALT) begin
                        mdl_halt = 1'b1;
                    end
                end
                OP_NEG: mdl_regs[r] = -a;
                OP_ADD: mdl_regs[r] = a + b;
                OP_SUB: mdl_regs[r] = a - b;
                OP_MUL: mdl_regs[r] = a * b;
                OP_DIV, OP_MOD: begin
                    if (sb == 0) begin
                        mdl_regs[r] = '0;
                        res.flt = FAULT_DIV0;
                    end else begin
                        mdl_regs[r] = (op == OP_DIV) ? 32'(sa / sb) : 32'(sa % sb);
                    end
                end
                OP_ODD: mdl_regs[r] = {31'd0, mdl_regs[r][0]};
                OP_EQL: mdl_regs[r] = {31'd0, sa == sb};
                OP_NEQ: mdl_regs[r] = {31'd0, sa != sb};
                OP_LSS: mdl_regs[r] = {31'd0, sa < sb};
                OP_LEQ: mdl_regs[r] = {31'd0, sa <= sb};
                OP_GTR: mdl_regs[r] = {31'd0, sa > sb};
                OP_GEQ: mdl_regs[r] = {31'd0, sa >= sb};
                default: ;
            endcase
        end
        res.pc   = mdl_pc;
        res.bp   = mdl_bp;
        res.sp   = mdl_sp;
        res.halt = mdl_halt;
        return res;
    endfunction

    // Valid stays high into the next transaction when no idle cycles are drawn.
    task automatic send_instr(logic [4:0] op, logic [2:0] r, logic [3:0] lv,
                              logic [31:0] m, logic [31:0] rd);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_reg_sel    <= r;
        i_level_sel  <= lv;
        i_operand_m  <= m;
        i_read_value <= rd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_steps.push_back(execute_instr(op, r, lv, m, rd));
        sent++;
    endtask

    // Result checker and receiver stall.
    initial begin
        t_step_out exp_res, got;
        int hold;
        i_stall = 1'b1;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = '{o_next_pc, o_base_ptr_out, o_stack_ptr_out, o_out_valid,
                        o_out_value, o_halted, o_fault};
                if (pending_steps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_res = pending_steps.pop_front();
                    checked++;
                    if (got !== exp_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch pc %h/%h bp %h/%h sp %h/%h ov %b/%b",
                                      " val %h/%h halt %b/%b flt %0d/%0d"},
                                     exp_res.pc, got.pc, exp_res.bp, got.bp,
                                     exp_res.sp, got.sp, exp_res.ov, got.ov,
                                     exp_res.oval, got.oval, exp_res.halt, got.halt,
                                     exp_res.flt, got.flt);
                    end
                end
                hold = $urandom_range(0, 3);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: cycles without any accepted transaction.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'(longint'($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_registers();
        send_instr(OP_LIT, 3'd0, 4'd0, 32'h8000_0000, '0);
        send_instr(OP_LIT, 3'd1, 4'd0, 32'hffff_ffff, '0);
        send_instr(OP_LIT, 3'd2, 4'd0, 32'h7fff_ffff, '0);
        send_instr(OP_LIT, 3'd7, 4'd0, 32'd0, '0);
        send_instr(OP_DIV, 3'd3, 4'd0, 32'd1, '0);   // overflowing division
        send_instr(OP_MOD, 3'd4, 4'd0, 32'd1, '0);
        send_instr(OP_DIV, 3'd5, 4'd2, 32'd7, '0);   // zero divisor
        send_instr(OP_MOD, 3'd5, 4'd9, 32'hffff_fff7, '0);
        send_instr(OP_NEG, 3'd6, 4'd0, 32'd0, '0);
        send_instr(OP_ADD, 3'd6, 4'd2, 32'd2, '0);
        send_instr(OP_MUL, 3'd6, 4'd2, 32'd2, '0);
        send_instr(OP_ODD, 3'd1, 4'd0, 32'd0, '0);
        for (int op = OP_SUB; op <= OP_GEQ; op++)
            send_instr(5'(op), 3'(op), 4'd0, 32'd1, '0);
        send_instr(OP_SIO, 3'd2, 4'd0, SIO_IN, 32'hdead_beef);
        send_instr(OP_SIO, 3'd2, 4'd0, SIO_OUT, '0);
        send_instr(OP_SIO, 3'd2, 4'd0, 32'd7, '0);
        send_instr(5'd0, 3'd0, 4'd0, 32'd0, '0);
        send_instr(5'd31, 3'd7, 4'd15, 32'hffff_ffff, '1);
    endtask

    task automatic test_stack_frames();
        send_instr(OP_INC, 3'd0, 4'd0, 32'd4, '0);
        send_instr(OP_STO, 3'd2, 4'd0, 32'd4, '0);
        send_instr(OP_LOD, 3'd5, 4'd0, 32'd4, '0);
        send_instr(OP_CAL, 3'd0, 4'd0, 32'd40, '0);
        send_instr(OP_LOD, 3'd3, 4'd1, 32'd1, '0);
        send_instr(OP_RTN, 3'd0, 4'd0, 32'd0, '0);
        send_instr(OP_LOD, 3'd3, 4'd0, 32'h8000_0000, '0);  // out of range
        send_instr(OP_STO, 3'd3, 4'd15, 32'd5000, '0);
        send_instr(OP_JPC, 3'd7, 4'd0, 32'h0000_1abc, '0);
        send_instr(OP_JMP, 3'd0, 4'd0, 32'hffff_f005, '0);
    endtask

    task automatic test_random(int count);
        logic [4:0] op;
        logic [31:0] m;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(1, 22));
            case (op)
                OP_LOD, OP_STO: m = ($urandom_range(0, 9) == 0) ? rand_word()
                                                                : 32'($urandom_range(0, 12));
                OP_INC: m = ($urandom_range(0, 9) == 0) ? rand_word()
                                                        : 32'($urandom_range(0, 6));
                OP_SIO: m = ($urandom_range(0, 5) == 0) ? rand_word()
                                                        : 32'($urandom_range(1, 2));
                OP_DIV, OP_MOD, OP_ADD, OP_SUB, OP_MUL: m = rand_word();
                default: m = ($urandom_range(0, 3) == 0) ? rand_word()
                                                         : 32'($urandom_range(0, 4095));
            endcase
            // Keep the stack pointer and base pointer mostly inside the stack.
            if (op == OP_INC && mdl_sp > 12'd1800) m = 32'hffff_ff00;
            if (op == OP_CAL && mdl_sp > 12'd1800) op = OP_RTN;
            if (op == OP_SIO && m == SIO_HALT && $urandom_range(0, 3) != 0) m = SIO_OUT;
            send_instr(op, 3'($urandom), ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                                    : 4'($urandom_range(0, 2)),
                       m, rand_word());
            if (op == OP_LIT && $urandom_range(0, 1) == 0)
                send_instr(OP_SIO, 3'($urandom), 4'd0, SIO_OUT, '0);
        end
    endtask

    task automatic test_halt();
        send_instr(OP_SIO, 3'd0, 4'd0, SIO_HALT, '0);
        send_instr(OP_LIT, 3'd1, 4'd0, 32'd5, '0);
        send_instr(OP_SIO, 3'd1, 4'd0, SIO_OUT, '0);
        send_instr(OP_DIV, 3'd1, 4'd0, 32'd7, '0);
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) mdl_stack[i] = '0;
        for (int i = 0; i < 8; i++) mdl_regs[i] = '0;
        mdl_pc = '0;
        mdl_bp = 12'd1;
        mdl_sp = '0;
        mdl_halt = 1'b0;
        mismatches = 0;
        checked = 0;
        sent = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = '0;
        i_reg_sel = '0;
        i_level_sel = '0;
        i_operand_m = '0;
        i_read_value = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_registers();
        test_stack_frames();
        test_random(850);
        test_halt();
        i_valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d instructions, checked %0d results (registers, frames,",
                 sent, checked);
        $display("faults, I/O, random programs and halt).");
        if (mismatches == 0 && pending_steps.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/pm0_pkg.sv
rtl/pm0_register_stack_machine_step.sv
rtl/pm0_checker.sv
test/testbench.sv
